>>> rtl/tlvd_pkg.sv
package tlvd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdW     = 16;
  localparam int unsigned LenW    = 24;
  localparam int unsigned KindW   = 2;

  // One input transaction: a buffer byte and its end-of-buffer mark.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             buffer_end;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [KindW-1:0] ident_kind;
    logic [IdW-1:0]   record_id;
    logic [LenW-1:0]  record_length;
    logic [ByteW-1:0] value_byte;
    logic             byte_valid;
    logic             last_of_value;
    logic             status;
  } result_t;

endpackage

>>> rtl/tlv_stream_decoder.sv
// An accepted byte is held in the input register, then decoded; any result it makes
// is written to the result register, which drives the outputs.
// Throughput: 1 byte per cycle while the output does not stall; the phase update for a
// byte is one pass of logic between the input register and the result register.
// Backpressure on the output stalls the input register, which stalls in_ready.
// Reset (rst, synchronous, active high): empties both registers, decoder waits for a header.
module tlv_stream_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tlvd_pkg::ByteW-1:0] data_byte,
  input  logic                       buffer_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tlvd_pkg::KindW-1:0] ident_kind,
  output logic [tlvd_pkg::IdW-1:0]   record_id,
  output logic [tlvd_pkg::LenW-1:0]  record_length,
  output logic [tlvd_pkg::ByteW-1:0] value_byte,
  output logic                       byte_valid,
  output logic                       last_of_value,
  output logic                       status
);
  import tlvd_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  result_t res;

  // Pack the input transaction.
  assign in_item.data_byte  = data_byte;
  assign in_item.buffer_end = buffer_end;

  // Input register: holds one byte while the decoder waits on the output side.
  tlvd_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take)
  );

  // Phase tracking, field accumulation and the result register.
  tlvd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Unpack the result transaction onto its ports.
  assign ident_kind    = res.ident_kind;
  assign record_id     = res.record_id;
  assign record_length = res.record_length;
  assign value_byte    = res.value_byte;
  assign byte_valid    = res.byte_valid;
  assign last_of_value = res.last_of_value;
  assign status        = res.status;

endmodule

>>> rtl/tlvd_in_stage.sv
module tlvd_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlvd_pkg::item_t in_item,
  output logic            item_valid,
  output tlvd_pkg::item_t item,
  input  logic            item_take
);
  import tlvd_pkg::*;

  logic full;

  assign in_ready   = !full || item_take;
  assign item_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (item_take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> rtl/tlvd_core.sv
module tlvd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  tlvd_pkg::item_t   item,
  output logic              item_take,
  output logic              out_valid,
  input  logic              out_ready,
  output tlvd_pkg::result_t res
);
  import tlvd_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;

  logic [2:0]       phase,        phase_next;
  logic [KindW-1:0] kind_reg,     kind_reg_next;
  logic             wide_id_flag, wide_id_flag_next;
  logic [1:0]       length_form,  length_form_next;
  logic [IdW-1:0]   id_accum,     id_accum_next;
  logic [LenW-1:0]  length_accum, length_accum_next;
  logic [LenW-1:0]  bytes_left,   bytes_left_next;
  logic [1:0]       field_count,  field_count_next;

  logic             emit;
  logic             valid_bit;
  logic             last_bit;
  logic             status_bit;
  logic [ByteW-1:0] vb;
  logic [1:0]       fc_dec;
  logic [LenW-1:0]  left_dec;
  logic             fire;

  assign fire      = item_valid && (!out_valid || out_ready);
  assign item_take = fire;
  assign fc_dec    = 2'(field_count - 2'd1);
  assign left_dec  = LenW'(bytes_left - 1'b1);

  always_comb begin
    phase_next        = phase;
    kind_reg_next     = kind_reg;
    wide_id_flag_next = wide_id_flag;
    length_form_next  = length_form;
    id_accum_next     = id_accum;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    field_count_next  = field_count;
    emit       = 1'b0;
    valid_bit  = 1'b0;
    last_bit   = 1'b0;
    status_bit = 1'b0;
    vb         = '0;

    unique case (phase)
      PH_ID: begin
        id_accum_next    = {id_accum[IdW-ByteW-1:0], item.data_byte};
        field_count_next = fc_dec;
        if (fc_dec == 2'd0) begin
          if (length_form == 2'd0) begin
            if (length_accum == '0) begin
              phase_next = PH_HEADER;
              emit       = 1'b1;
              last_bit   = 1'b1;
            end else begin
              bytes_left_next = length_accum;
              phase_next      = PH_VALUE;
            end
          end else begin
            field_count_next = length_form;
            phase_next       = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        length_accum_next = {length_accum[LenW-ByteW-1:0], item.data_byte};
        field_count_next  = fc_dec;
        if (fc_dec == 2'd0) begin
          if (length_accum_next == '0) begin
            phase_next = PH_HEADER;
            emit       = 1'b1;
            last_bit   = 1'b1;
          end else begin
            bytes_left_next = length_accum_next;
            phase_next      = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        bytes_left_next = left_dec;
        emit      = 1'b1;
        valid_bit = 1'b1;
        vb        = item.data_byte;
        if (left_dec == '0) begin
          last_bit   = 1'b1;
          phase_next = PH_HEADER;
        end
      end
      default: begin
        // Header byte; unused phase codes land here too.
        kind_reg_next     = item.data_byte[7:6];
        wide_id_flag_next = item.data_byte[5];
        length_form_next  = item.data_byte[4:3];
        id_accum_next     = '0;
        length_accum_next = (item.data_byte[4:3] == 2'd0) ?
                            LenW'(item.data_byte[2:0]) : '0;
        bytes_left_next   = '0;
        field_count_next  = item.data_byte[5] ? 2'd2 : 2'd1;
        phase_next        = PH_ID;
      end
    endcase

    // Truncated record: replace whatever the byte produced with an error.
    if (item.buffer_end && phase_next != PH_HEADER) begin
      emit             = 1'b1;
      valid_bit        = 1'b0;
      vb               = '0;
      last_bit         = 1'b0;
      status_bit       = 1'b1;
      phase_next       = PH_HEADER;
      bytes_left_next  = '0;
      field_count_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      kind_reg     <= '0;
      wide_id_flag <= 1'b0;
      length_form  <= 2'd0;
      id_accum     <= '0;
      length_accum <= '0;
      bytes_left   <= '0;
      field_count  <= 2'd0;
    end else if (fire) begin
      phase        <= phase_next;
      kind_reg     <= kind_reg_next;
      wide_id_flag <= wide_id_flag_next;
      length_form  <= length_form_next;
      id_accum     <= id_accum_next;
      length_accum <= length_accum_next;
      bytes_left   <= bytes_left_next;
      field_count  <= field_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res.ident_kind    <= kind_reg_next;
      res.record_id     <= id_accum_next;
      res.record_length <= length_accum_next;
      res.value_byte    <= vb;
      res.byte_valid    <= valid_bit;
      res.last_of_value <= last_bit;
      res.status        <= status_bit;
    end
  end

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.status |-> !res.byte_valid && !res.last_of_value && res.value_byte == '0)
    else $error("error result carries value data");

  a_end_to_header: assert property (@(posedge clk) disable iff (rst)
    fire && item.buffer_end |=> phase == PH_HEADER)
    else $error("buffer end did not return to header phase");

  a_value_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_VALUE |-> bytes_left != '0)
    else $error("value phase with nothing left");

  a_value_emits: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_VALUE && !item.buffer_end |=> out_valid && res.byte_valid)
    else $error("value byte not emitted");

endmodule
